### rtl/core/led_blink_pattern_generator_unit_defines.svh
// ----------------------------------------------------------------------------
// LED blink pattern generator assertion macros
// Shared concurrent assertion forms used by the blink generator RTL.
// ----------------------------------------------------------------------------
`ifndef LED_BLINK_PATTERN_GENERATOR_UNIT_DEFINES_SVH
`define LED_BLINK_PATTERN_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LBPG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LBPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/lbpg_pkg.sv
// ----------------------------------------------------------------------------
// LED blink pattern generator package
// Command and result item types, action codes and register indexes.
// ----------------------------------------------------------------------------
package lbpg_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned TICKS_W     = 32;
  localparam int unsigned COUNT_W     = 8;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_ON_TICKS    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFF_TICKS   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BLINK_COUNT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DELAY_TICKS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ON_LEVEL    = 3'd4;

  // Reset values of the on and off tick registers.
  localparam logic [TICKS_W-1:0] ON_TICKS_RESET  = 32'd500;
  localparam logic [TICKS_W-1:0] OFF_TICKS_RESET = 32'd500;

  typedef enum logic [1:0] {
    ACT_TICK        = 2'd0,
    ACT_START       = 2'd1,
    ACT_START_COUNT = 2'd2,
    ACT_STOP        = 2'd3
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [COUNT_W-1:0] new_count;
  } cmd_t;

  typedef struct packed {
    logic       pin_level;
    logic       running;
    logic [1:0] phase;
  } result_t;

endpackage

### rtl/core/led_blink_pattern_generator_unit.sv
// ----------------------------------------------------------------------------
// LED blink pattern generator
// Tick-driven blinker with burst count, inter-burst pause and polarity.
// ----------------------------------------------------------------------------
// Usage: each command item on the cmd channel is either a one-millisecond
// tick, a start, a start with a burst count, or a stop. Every accepted item
// produces exactly one result item on the result channel carrying the pin
// level, the running flag and the phase after that item was applied.
// The result of an accepted item is registered into the output register,
// or into the skid register while the output one is held. Throughput is one
// item per cycle while cmd_stall is low; the 32-bit elapsed increment and
// compare against the current period sit between the state registers.
// The result side is an output register backed by a one-entry skid register,
// so a new item is still taken while a finished result waits. Only when the
// skid register is also occupied does cmd_stall rise, and it falls right
// after the first clock edge at which the receiver takes the waiting result.
// Reset (synchronous, active high) loads the configuration defaults (500 ms
// on and off, endless blinking, no pause, active-high pin), stops the
// blinker in the off phase with the pin low, and empties both result slots.
// Configuration writes take effect at the clock edge with cfg_write high;
// indexes beyond the register list are ignored.
module led_blink_pattern_generator_unit
  import lbpg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  cmd_t                   cmd,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result
);

`include "led_blink_pattern_generator_unit_defines.svh"

  typedef enum logic [1:0] {
    PHASE_OFF  = 2'd0,
    PHASE_ON   = 2'd1,
    PHASE_WAIT = 2'd2
  } phase_t;

  // Configuration registers.
  logic [TICKS_W-1:0] on_ticks;
  logic [TICKS_W-1:0] off_ticks;
  logic [COUNT_W-1:0] blink_count;
  logic [TICKS_W-1:0] delay_ticks;
  logic               on_level;

  // Blinker state.
  phase_t             phase;
  logic [COUNT_W-1:0] pulse_counter;
  logic [TICKS_W-1:0] elapsed;
  logic [TICKS_W-1:0] period;
  logic               running;
  logic               pin;
  logic [COUNT_W-1:0] override_count;
  logic               override_active;

  phase_t             phase_next;
  logic [COUNT_W-1:0] pulse_counter_next;
  logic [TICKS_W-1:0] elapsed_next;
  logic [TICKS_W-1:0] period_next;
  logic               running_next;
  logic               pin_next;
  logic [COUNT_W-1:0] override_count_next;
  logic               override_active_next;

  // Result slots: output register plus skid register.
  result_t            skid;
  logic               skid_valid;
  result_t            result_next;

  logic               cmd_accept;
  logic               out_free;
  logic [TICKS_W-1:0] elapsed_inc;
  logic [COUNT_W-1:0] limit;
  logic [TICKS_W-1:0] pause;
  logic [COUNT_W-1:0] fired_count;

  assign cmd_stall  = skid_valid;
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign out_free   = !result_valid || !result_stall;

  // A start with count switches the burst limit to the override and drops
  // the pause for good.
  assign limit       = override_active ? override_count : blink_count;
  assign pause       = override_active ? '0 : delay_ticks;
  assign elapsed_inc = (elapsed == '1) ? elapsed : elapsed + 1'b1;
  assign fired_count = (phase == PHASE_ON) ? pulse_counter + 1'b1 : pulse_counter;

  always_comb begin
    phase_next           = phase;
    pulse_counter_next   = pulse_counter;
    elapsed_next         = elapsed;
    period_next          = period;
    running_next         = running;
    pin_next             = pin;
    override_count_next  = override_count;
    override_active_next = override_active;

    case (cmd.action)
      ACT_TICK: begin
        if (running) begin
          elapsed_next = elapsed_inc;
          if (elapsed_inc >= period) begin
            elapsed_next       = '0;
            pulse_counter_next = fired_count;
            if (phase == PHASE_ON) begin
              // End of the on time: one full pulse is done.
              pin_next    = ~on_level;
              phase_next  = PHASE_OFF;
              period_next = off_ticks;
            end else begin
              pin_next    = on_level;
              phase_next  = PHASE_ON;
              period_next = on_ticks;
            end
            if ((limit != '0) && (fired_count >= limit)) begin
              pulse_counter_next = '0;
              if (pause != '0) begin
                phase_next  = PHASE_WAIT;
                period_next = pause;
              end else begin
                running_next = 1'b0;
              end
            end
          end
        end
      end
      ACT_START, ACT_START_COUNT: begin
        if (cmd.action == ACT_START_COUNT) begin
          override_count_next  = cmd.new_count;
          override_active_next = 1'b1;
        end
        // Period zero makes the first tick turn the output on.
        phase_next         = PHASE_OFF;
        pulse_counter_next = '0;
        period_next        = '0;
        elapsed_next       = '0;
        running_next       = 1'b1;
      end
      default: begin
        // Stop only deschedules; pin, phase and counters hold.
        running_next = 1'b0;
      end
    endcase

    result_next.pin_level = pin_next;
    result_next.running   = running_next;
    result_next.phase     = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_ticks        <= ON_TICKS_RESET;
      off_ticks       <= OFF_TICKS_RESET;
      blink_count     <= '0;
      delay_ticks     <= '0;
      on_level        <= 1'b1;
      phase           <= PHASE_OFF;
      pulse_counter   <= '0;
      elapsed         <= '0;
      period          <= '0;
      running         <= 1'b0;
      pin             <= 1'b0;
      override_count  <= '0;
      override_active <= 1'b0;
      result_valid    <= 1'b0;
      skid_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ON_TICKS:    on_ticks    <= cfg_data[TICKS_W-1:0];
          REG_OFF_TICKS:   off_ticks   <= cfg_data[TICKS_W-1:0];
          REG_BLINK_COUNT: blink_count <= cfg_data[COUNT_W-1:0];
          REG_DELAY_TICKS: delay_ticks <= cfg_data[TICKS_W-1:0];
          REG_ON_LEVEL:    on_level    <= cfg_data[0];
          default: begin
          end
        endcase
      end

      if (cmd_accept) begin
        phase           <= phase_next;
        pulse_counter   <= pulse_counter_next;
        elapsed         <= elapsed_next;
        period          <= period_next;
        running         <= running_next;
        pin             <= pin_next;
        override_count  <= override_count_next;
        override_active <= override_active_next;
      end

      // The skid register only fills while the output register is held, and
      // drains into it first, so items leave in order.
      if (out_free) begin
        if (skid_valid) begin
          result       <= skid;
          result_valid <= 1'b1;
          skid_valid   <= 1'b0;
        end else if (cmd_accept) begin
          result       <= result_next;
          result_valid <= 1'b1;
        end else begin
          result_valid <= 1'b0;
        end
      end else if (cmd_accept) begin
        skid       <= result_next;
        skid_valid <= 1'b1;
      end
    end
  end

  `LBPG_ASSERT_NOW(a_skid_behind_output, clk, rst, skid_valid, result_valid,
                   "skid register holds an item while the output register is empty")

  `LBPG_ASSERT_NEXT(a_start_restarts, clk, rst,
                    cmd_accept && (cmd.action == ACT_START || cmd.action == ACT_START_COUNT),
                    running && (phase == PHASE_OFF) && (elapsed == '0) && (period == '0),
                    "start did not restart the blinker from the off phase")

  `LBPG_ASSERT_NEXT(a_stop_deschedules, clk, rst,
                    cmd_accept && (cmd.action == ACT_STOP),
                    !running && $stable(pin) && $stable(phase),
                    "stop changed more than the running flag")

  `LBPG_ASSERT_NEXT(a_idle_tick_holds, clk, rst,
                    cmd_accept && (cmd.action == ACT_TICK) && !running,
                    $stable(pin) && $stable(phase) && $stable(elapsed) && !running,
                    "tick while stopped changed the blinker state")

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED blink pattern generator testbench
// Drives tick, start, start-with-count and stop items into the blinker,
// keeps its own copy of the blinker state to predict every status item, and
// compares each returned item field by field under random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import lbpg_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLDOFF_CYCLES = 60;
  localparam int unsigned PRINT_LIMIT    = 40;

  typedef enum logic [1:0] {
    PHASE_OFF  = 2'd0,
    PHASE_ON   = 2'd1,
    PHASE_WAIT = 2'd2
  } phase_t;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   cfg_write    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;
  logic                   cmd_valid    = 1'b0;
  logic                   cmd_stall;
  cmd_t                   cmd          = '{action: ACT_TICK, new_count: '0};
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result;

  led_blink_pattern_generator_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #5 clk = ~clk;

  // Configuration copy and blinker state of the predictor.
  logic [TICKS_W-1:0] cfg_on;
  logic [TICKS_W-1:0] cfg_off;
  logic [COUNT_W-1:0] cfg_count;
  logic [TICKS_W-1:0] cfg_delay;
  logic               cfg_level;

  phase_t             blink_phase;
  logic [COUNT_W-1:0] pulses_done;
  logic [TICKS_W-1:0] ticks_elapsed;
  logic [TICKS_W-1:0] ticks_period;
  logic               blink_running;
  logic               pin_now;
  logic [COUNT_W-1:0] forced_count;
  logic               forced_active;

  result_t pending_status[$];

  int unsigned error_count  = 0;
  bit          idle_on      = 1'b1;
  bit          holdoff_req  = 1'b0;
  int unsigned holdoff_left = 0;
  int unsigned stall_left   = 0;
  int unsigned run_left     = 0;
  int unsigned quiet_cycles = 0;

  // Gap lengths: mostly short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    else if (r < 95) return $urandom_range(3, 8);
    else return $urandom_range(20, 60);
  endfunction

  // Tick periods stay small so that many pulses happen, with rare extremes.
  function automatic logic [TICKS_W-1:0] pick_ticks();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 4);
    else if (r < 90) return $urandom_range(5, 40);
    else if (r < 95) return '0;
    else return '1;
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return '0;
    else if (r < 90) return COUNT_W'($urandom_range(1, 6));
    else return '1;
  endfunction

  function automatic cmd_t pick_command(bit allow_count);
    cmd_t        c;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) c.action = ACT_TICK;
    else if (r < 88) c.action = ACT_START;
    else if (r < 94) c.action = allow_count ? ACT_START_COUNT : ACT_TICK;
    else c.action = ACT_STOP;
    c.new_count = $urandom_range(0, 1) ? COUNT_W'($urandom_range(0, 6)) : COUNT_W'($urandom());
    return c;
  endfunction

  task automatic reset_blinker_model();
    cfg_on        = ON_TICKS_RESET;
    cfg_off       = OFF_TICKS_RESET;
    cfg_count     = '0;
    cfg_delay     = '0;
    cfg_level     = 1'b1;
    blink_phase   = PHASE_OFF;
    pulses_done   = '0;
    ticks_elapsed = '0;
    ticks_period  = '0;
    blink_running = 1'b0;
    pin_now       = 1'b0;
    forced_count  = '0;
    forced_active = 1'b0;
  endtask

  // Applies one accepted command to the predicted state and queues the
  // status item the blinker must answer with.
  task automatic advance_blinker(input cmd_t c);
    logic [COUNT_W-1:0] burst_len;
    logic [TICKS_W-1:0] pause_len;
    result_t            status;
    burst_len = forced_active ? forced_count : cfg_count;
    pause_len = forced_active ? '0 : cfg_delay;
    case (c.action)
      ACT_TICK: begin
        if (blink_running) begin
          if (ticks_elapsed != '1) ticks_elapsed = ticks_elapsed + 1'b1;
          if (ticks_elapsed >= ticks_period) begin
            ticks_elapsed = '0;
            if (blink_phase == PHASE_ON) begin
              pin_now      = ~cfg_level;
              pulses_done  = pulses_done + 1'b1;
              blink_phase  = PHASE_OFF;
              ticks_period = cfg_off;
            end else begin
              pin_now      = cfg_level;
              blink_phase  = PHASE_ON;
              ticks_period = cfg_on;
            end
            // The compare is greater-or-equal, so a lowered count ends a
            // burst at the next phase change.
            if (burst_len != '0 && pulses_done >= burst_len) begin
              pulses_done = '0;
              if (pause_len != '0) begin
                blink_phase  = PHASE_WAIT;
                ticks_period = pause_len;
              end else begin
                blink_running = 1'b0;
              end
            end
          end
        end
      end
      ACT_START, ACT_START_COUNT: begin
        if (c.action == ACT_START_COUNT) begin
          forced_count  = c.new_count;
          forced_active = 1'b1;
        end
        blink_phase   = PHASE_OFF;
        pulses_done   = '0;
        ticks_period  = '0;
        ticks_elapsed = '0;
        blink_running = 1'b1;
      end
      default: begin
        blink_running = 1'b0;
      end
    endcase
    status.pin_level = pin_now;
    status.running   = blink_running;
    status.phase     = blink_phase;
    pending_status.push_back(status);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("%0t: mismatch in %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  // Sends one item. Called right after a rising edge; returns right after
  // the edge at which the item was accepted.
  task automatic send_cmd(input action_t act, input logic [COUNT_W-1:0] count);
    int unsigned gap;
    cmd_t        c;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    c.action    = act;
    c.new_count = count;
    cmd_valid <= 1'b1;
    cmd       <= c;
    forever begin
      @(posedge clk);
      if (!cmd_stall) break;
    end
    advance_blinker(c);
  endtask

  // Lets every outstanding status item come back before touching registers.
  task automatic settle_block();
    cmd_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_ON_TICKS:    cfg_on    = data;
      REG_OFF_TICKS:   cfg_off   = data;
      REG_BLINK_COUNT: cfg_count = data[COUNT_W-1:0];
      REG_DELAY_TICKS: cfg_delay = data;
      REG_ON_LEVEL:    cfg_level = data[0];
      default: ;
    endcase
  endtask

  task automatic program_blinker(input logic [TICKS_W-1:0] on_t, input logic [TICKS_W-1:0] off_t,
                                 input logic [COUNT_W-1:0] count, input logic [TICKS_W-1:0] delay,
                                 input logic level);
    settle_block();
    write_reg(REG_ON_TICKS, on_t);
    write_reg(REG_OFF_TICKS, off_t);
    write_reg(REG_BLINK_COUNT, CFG_DATA_W'(count));
    write_reg(REG_DELAY_TICKS, delay);
    write_reg(REG_ON_LEVEL, CFG_DATA_W'(level));
    // Indexes past the register list must leave every register alone.
    write_reg(CFG_INDEX_W'($urandom_range(5, 7)), $urandom());
  endtask

  task automatic test_reset_defaults();
    send_cmd(ACT_TICK, 8'hFF);
    send_cmd(ACT_STOP, 8'h00);
    send_cmd(ACT_START, 8'hA5);
    send_cmd(ACT_TICK, 8'h5A);
    send_cmd(ACT_TICK, 8'h00);
    send_cmd(ACT_STOP, 8'hFF);
    send_cmd(ACT_TICK, 8'h00);
  endtask

  task automatic test_burst_and_pause();
    program_blinker('0, '0, 8'd5, 32'd1, 1'b0);
    write_reg(3'd7, '1);
    send_cmd(ACT_START, 8'h00);
    repeat (6) send_cmd(ACT_TICK, 8'h00);
    // Three pulses are done; dropping the count below that ends the burst.
    settle_block();
    write_reg(REG_BLINK_COUNT, 32'd2);
    repeat (4) send_cmd(ACT_TICK, 8'h00);
    settle_block();
    write_reg(REG_ON_LEVEL, 32'd1);
    send_cmd(ACT_TICK, 8'h00);
    send_cmd(ACT_STOP, 8'h00);
    send_cmd(ACT_TICK, 8'h00);
  endtask

  task automatic test_count_override();
    // The configured count and pause are ignored once an override is set.
    program_blinker(32'd0, 32'd1, 8'd1, 32'd3, 1'b1);
    send_cmd(ACT_START_COUNT, 8'd2);
    repeat (7) send_cmd(ACT_TICK, 8'h00);
    send_cmd(ACT_START, 8'h00);
    send_cmd(ACT_TICK, 8'h00);
  endtask

  task automatic test_output_backpressure();
    bit   saved_idle;
    cmd_t c;
    settle_block();
    saved_idle  = idle_on;
    idle_on     = 1'b0;
    holdoff_req = 1'b1;
    send_cmd(ACT_START, 8'h00);
    repeat (15) begin
      c = pick_command(1'b0);
      send_cmd(c.action, 8'h00);
    end
    idle_on = saved_idle;
  endtask

  task automatic run_random_phase(input int unsigned items, input bit allow_count);
    cmd_t c;
    program_blinker(pick_ticks(), pick_ticks(), pick_count(), pick_ticks(), 1'($urandom()));
    idle_on = ($urandom_range(0, 4) != 0);
    send_cmd(ACT_START, COUNT_W'($urandom()));
    repeat (items) begin
      c = pick_command(allow_count);
      send_cmd(c.action, c.new_count);
    end
  endtask

  task automatic test_random_plain();
    repeat (6) run_random_phase(150, 1'b0);
  endtask

  task automatic test_random_override();
    repeat (6) run_random_phase(150, 1'b1);
  endtask

  // Result receiver: random stalls, plus the long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (holdoff_req) begin
      holdoff_req  = 1'b0;
      holdoff_left = HOLDOFF_CYCLES;
      result_stall <= 1'b1;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      result_stall <= 1'b1;
    end else if (!idle_on) begin
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (run_left > 0) begin
      run_left--;
      result_stall <= 1'b0;
    end else begin
      stall_left = pick_gap();
      run_left   = $urandom_range(0, 12);
      result_stall <= 1'b0;
    end
  end

  // Status checker.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_status.size() == 0) begin
        report_mismatch("unexpected status item", '0, 32'(result));
      end else begin
        want = pending_status.pop_front();
        if (result.pin_level !== want.pin_level)
          report_mismatch("pin_level", 32'(want.pin_level), 32'(result.pin_level));
        if (result.running !== want.running)
          report_mismatch("running", 32'(want.running), 32'(result.running));
        if (result.phase !== want.phase)
          report_mismatch("phase", 32'(want.phase), 32'(result.phase));
      end
    end
  end

  // Watchdog on cycles with no handshake and no register write.
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (result_valid && !result_stall) || cfg_write) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[led_blink_pattern_generator_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    reset_blinker_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_burst_and_pause();
    test_random_plain();
    test_output_backpressure();
    test_count_override();
    test_random_override();
    settle_block();
    repeat (10) @(posedge clk);
    if (error_count == 0 && pending_status.size() == 0) begin
      $display("[led_blink_pattern_generator_unit] OK");
    end else begin
      $display("[led_blink_pattern_generator_unit] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/lbpg_pkg.sv
rtl/core/led_blink_pattern_generator_unit.sv
tb/tb_top.sv
